// ----- rtl/core/i2c_mbe_pkg.sv -----
package i2c_mbe_pkg;

	// configuration register width and index codes
	localparam int HALF_W    = 16;
	localparam int TMO_W     = 8;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_W     = 16;

	localparam logic [CFG_IDX_W-1:0] REG_HALF_PHASE  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ACK_TIMEOUT = 2'd1;

	// command codes
	localparam logic [2:0] ACT_START = 3'd0;
	localparam logic [2:0] ACT_STOP  = 3'd1;
	localparam logic [2:0] ACT_WRITE = 3'd2;
	localparam logic [2:0] ACT_WAIT  = 3'd3;
	localparam logic [2:0] ACT_READ  = 3'd4;

	localparam logic [3:0] BITS_PER_BYTE = 4'd8;

	// sequencer steps
	typedef enum logic [4:0] {
		ST_IDLE      = 5'd0,
		ST_START_B   = 5'd1,
		ST_START_C   = 5'd2,
		ST_STOP_B    = 5'd3,
		ST_STOP_C    = 5'd4,
		ST_WR_DATA   = 5'd5,
		ST_WR_HIGH   = 5'd6,
		ST_WR_LOW    = 5'd7,
		ST_WR_REL    = 5'd8,
		ST_ACK_HIGH  = 5'd9,
		ST_ACK_POLL  = 5'd10,
		ST_RD_SAMPLE = 5'd11,
		ST_RD_HIGH   = 5'd12,
		ST_K_DRIVE   = 5'd13,
		ST_K_HIGH    = 5'd14,
		ST_K_LOW     = 5'd15,
		ST_K_REL     = 5'd16,
		ST_FIN       = 5'd17
	} step_t;

	// one tick item as taken from the input channel
	typedef struct packed {
		logic       cmd_valid;
		logic [2:0] action;
		logic [7:0] wr_data;
		logic       send_ack;
		logic       sda_in;
	} tick_t;

	// one result item
	typedef struct packed {
		logic       scl_out;
		logic       sda_out;
		logic       busy_res;
		logic       done_res;
		logic [7:0] rd_data;
		logic       ack_missing;
	} res_t;

endpackage

// ----- rtl/core/i2c_master_bit_engine_unit.sv -----
// I2C master bit sequencer, one clock tick of the bus timing per transaction.
// Input channel s_*: each transaction is one tick, carrying the sampled SDA
// level and an optional command (start, stop, write byte, wait ack, read
// byte). A command is taken only while the sequencer is idle; otherwise it
// is ignored. Output channel m_*: exactly one result per input tick, giving
// the SCL and SDA levels after the tick, busy, a done pulse, the last read
// byte and the missing-ack flag.
// Config channel cfg_*: index 0 half phase ticks, index 1 ack timeout; other
// indexes are ignored. cfg_ready is always high. Write only while idle.
// Path: a taken tick passes the input register, then the result register.
// Throughput: one tick per cycle while m_tready does not stall, set by the single
// pass of the sequencer next-state logic between those two registers.
// A stalled m_tready holds the result and, once the input register is also
// full, drops s_tready; nothing is lost or repeated.
// Reset: both lines released, sequencer idle, half phase 10, ack timeout 250.
module i2c_master_bit_engine_unit
	import i2c_mbe_pkg::*;
#(
	parameter int TIMER_WIDTH = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [15:0]          s_tdata,   // wr_data[7:0], send_ack, sda_in
	input  logic [3:0]           s_tuser,   // cmd_valid, action[2:0]
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [15:0]          m_tdata,   // scl_out, sda_out, busy_res, done_res,
	                                        // rd_data[7:0], ack_missing
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data
);

	logic              valid_s1;
	tick_t             tick_s1;
	logic              out_valid_q;
	res_t              out_q;
	res_t              res;
	logic              advance;
	logic [HALF_W-1:0] half_phase_q;
	logic [TMO_W-1:0]  ack_timeout_q;

	assign advance   = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready  = !valid_s1 || advance;
	assign cfg_ready = 1'b1;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			half_phase_q  <= 16'd10;
			ack_timeout_q <= 8'd250;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_HALF_PHASE:  half_phase_q  <= cfg_data[HALF_W-1:0];
				REG_ACK_TIMEOUT: ack_timeout_q <= cfg_data[TMO_W-1:0];
				default: ;
			endcase
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tvalid && s_tready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			tick_s1.cmd_valid <= s_tuser[0];
			tick_s1.action    <= s_tuser[3:1];
			tick_s1.wr_data   <= s_tdata[7:0];
			tick_s1.send_ack  <= s_tdata[8];
			tick_s1.sda_in    <= s_tdata[9];
		end
	end

	i2c_mbe_seq #(
		.TIMER_WIDTH (TIMER_WIDTH)
	) u_seq (
		.clk         (clk),
		.arst_n      (arst_n),
		.step_en     (advance),
		.tick        (tick_s1),
		.half_phase  (half_phase_q),
		.ack_timeout (ack_timeout_q),
		.res         (res)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_q <= res;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {3'b000, out_q.ack_missing, out_q.rd_data, out_q.done_res,
		out_q.busy_res, out_q.sda_out, out_q.scl_out};

endmodule

// ----- rtl/core/i2c_mbe_seq.sv -----
module i2c_mbe_seq
	import i2c_mbe_pkg::*;
#(
	parameter int TIMER_WIDTH = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              step_en,
	input  tick_t             tick,
	input  logic [HALF_W-1:0] half_phase,
	input  logic [TMO_W-1:0]  ack_timeout,
	output res_t              res
);

	step_t                  step_q, step_d;
	logic [TIMER_WIDTH-1:0] phase_q, phase_d, phase_load;
	logic [3:0]             bit_q, bit_d, bit_inc;
	logic [7:0]             shift_q, shift_d, shift_rd;
	logic [7:0]             poll_q, poll_d;
	logic                   scl_q, scl_d, sda_q, sda_d;
	logic                   miss_q, miss_d, ackc_q, ackc_d;
	logic [7:0]             rdb_q, rdb_d;
	logic                   done;
	logic                   idle_go, run_op, hold;

	// hold length, saturated to what the timer holds
	generate
		if (TIMER_WIDTH > HALF_W) begin : g_wide
			assign phase_load = {{(TIMER_WIDTH-HALF_W){1'b0}}, half_phase};
		end else if (TIMER_WIDTH == HALF_W) begin : g_same
			assign phase_load = half_phase;
		end else begin : g_sat
			assign phase_load = (|half_phase[HALF_W-1:TIMER_WIDTH]) ? '1
				: half_phase[TIMER_WIDTH-1:0];
		end
	endgenerate

	assign idle_go  = (step_q == ST_IDLE) && tick.cmd_valid;
	assign hold     = (step_q != ST_IDLE) && (phase_q != '0);
	assign run_op   = (step_q != ST_IDLE) && (phase_q == '0);
	assign bit_inc  = bit_q + 4'd1;
	assign shift_rd = {shift_q[6:0], tick.sda_in};

	// next step
	always_comb begin
		step_d = step_q;
		if (idle_go) begin
			case (tick.action)
				ACT_START: step_d = ST_START_B;
				ACT_STOP:  step_d = ST_STOP_B;
				ACT_WRITE: step_d = ST_WR_HIGH;
				ACT_WAIT:  step_d = ST_ACK_HIGH;
				ACT_READ:  step_d = ST_RD_SAMPLE;
				default:   step_d = ST_IDLE;
			endcase
		end else if (run_op) begin
			case (step_q)
				ST_START_B:   step_d = ST_START_C;
				ST_START_C:   step_d = ST_FIN;
				ST_STOP_B:    step_d = ST_STOP_C;
				ST_STOP_C:    step_d = ST_FIN;
				ST_WR_DATA:   step_d = ST_WR_HIGH;
				ST_WR_HIGH:   step_d = ST_WR_LOW;
				ST_WR_LOW:    step_d = (bit_inc < BITS_PER_BYTE) ? ST_WR_DATA : ST_WR_REL;
				ST_WR_REL:    step_d = ST_FIN;
				ST_ACK_HIGH:  step_d = ST_ACK_POLL;
				ST_ACK_POLL: begin
					if (!tick.sda_in) begin
						step_d = ST_FIN;
					end else if (poll_q >= ack_timeout) begin
						step_d = ST_STOP_B;
					end
				end
				ST_RD_SAMPLE: step_d = (bit_inc < BITS_PER_BYTE) ? ST_RD_HIGH : ST_K_DRIVE;
				ST_RD_HIGH:   step_d = ST_RD_SAMPLE;
				ST_K_DRIVE:   step_d = ST_K_HIGH;
				ST_K_HIGH:    step_d = ST_K_LOW;
				ST_K_LOW:     step_d = ackc_q ? ST_K_REL : ST_FIN;
				ST_K_REL:     step_d = ST_FIN;
				default:      step_d = ST_IDLE;
			endcase
		end
	end

	// pin levels, timer, shifter and flags
	always_comb begin
		phase_d = phase_q;
		bit_d   = bit_q;
		shift_d = shift_q;
		poll_d  = poll_q;
		scl_d   = scl_q;
		sda_d   = sda_q;
		miss_d  = miss_q;
		ackc_d  = ackc_q;
		rdb_d   = rdb_q;
		done    = 1'b0;
		if (idle_go) begin
			case (tick.action)
				ACT_START: begin
					sda_d = 1'b1; scl_d = 1'b1; phase_d = phase_load;
				end
				ACT_STOP: begin
					sda_d = 1'b0; phase_d = phase_load;
				end
				ACT_WRITE: begin
					bit_d   = 4'd0;
					sda_d   = tick.wr_data[7];
					shift_d = {tick.wr_data[6:0], 1'b0};
					phase_d = phase_load;
				end
				ACT_WAIT: begin
					miss_d = 1'b0; sda_d = 1'b1; phase_d = phase_load;
				end
				ACT_READ: begin
					ackc_d  = tick.send_ack;
					shift_d = 8'd0;
					bit_d   = 4'd0;
					sda_d   = 1'b1;
					scl_d   = 1'b1;
					phase_d = phase_load;
				end
				default: ;
			endcase
		end else if (hold) begin
			phase_d = phase_q - {{(TIMER_WIDTH-1){1'b0}}, 1'b1};
		end else if (run_op) begin
			case (step_q)
				ST_START_B: begin sda_d = 1'b0; phase_d = phase_load; end
				ST_START_C: begin scl_d = 1'b0; phase_d = phase_load; end
				ST_STOP_B:  begin scl_d = 1'b1; phase_d = phase_load; end
				ST_STOP_C:  begin sda_d = 1'b1; phase_d = phase_load; end
				ST_WR_DATA: begin
					sda_d   = shift_q[7];
					shift_d = {shift_q[6:0], 1'b0};
					phase_d = phase_load;
				end
				ST_WR_HIGH: begin scl_d = 1'b1; phase_d = phase_load; end
				ST_WR_LOW: begin
					scl_d = 1'b0; phase_d = phase_load; bit_d = bit_inc;
				end
				ST_WR_REL: begin sda_d = 1'b1; phase_d = phase_load; end
				ST_ACK_HIGH: begin
					scl_d = 1'b1; phase_d = phase_load; poll_d = 8'd0;
				end
				ST_ACK_POLL: begin
					if (!tick.sda_in) begin
						scl_d = 1'b0; phase_d = phase_load;
					end else if (poll_q >= ack_timeout) begin
						miss_d = 1'b1; sda_d = 1'b0; phase_d = phase_load;
					end else begin
						poll_d = poll_q + 8'd1;
					end
				end
				ST_RD_SAMPLE: begin
					shift_d = shift_rd;
					scl_d   = 1'b0;
					phase_d = phase_load;
					bit_d   = bit_inc;
					if (!(bit_inc < BITS_PER_BYTE)) begin
						rdb_d = shift_rd;
					end
				end
				ST_RD_HIGH: begin scl_d = 1'b1; phase_d = phase_load; end
				ST_K_DRIVE: begin sda_d = ~ackc_q; phase_d = phase_load; end
				ST_K_HIGH:  begin scl_d = 1'b1; phase_d = phase_load; end
				ST_K_LOW:   begin scl_d = 1'b0; phase_d = phase_load; end
				ST_K_REL:   begin sda_d = 1'b1; phase_d = phase_load; end
				ST_FIN:     done = 1'b1;
				default: ;
			endcase
		end
	end

	// sequencer state, advanced once per tick
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q  <= ST_IDLE;
			phase_q <= '0;
			bit_q   <= 4'd0;
			shift_q <= 8'd0;
			poll_q  <= 8'd0;
			scl_q   <= 1'b1;
			sda_q   <= 1'b1;
			miss_q  <= 1'b0;
			ackc_q  <= 1'b0;
			rdb_q   <= 8'd0;
		end else if (step_en) begin
			step_q  <= step_d;
			phase_q <= phase_d;
			bit_q   <= bit_d;
			shift_q <= shift_d;
			poll_q  <= poll_d;
			scl_q   <= scl_d;
			sda_q   <= sda_d;
			miss_q  <= miss_d;
			ackc_q  <= ackc_d;
			rdb_q   <= rdb_d;
		end
	end

	// result of this tick, levels after the tick
	assign res.scl_out     = scl_d;
	assign res.sda_out     = sda_d;
	assign res.busy_res    = (step_d != ST_IDLE);
	assign res.done_res    = done;
	assign res.rd_data     = rdb_d;
	assign res.ack_missing = miss_d;

	// finishing tick always returns to idle
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		step_en && done |=> step_q == ST_IDLE)
		else $error("done without return to idle");

	// no step change while a hold is counting down
	a_hold_stable: assert property (@(posedge clk) disable iff (!arst_n)
		step_en && hold |=> step_q == $past(step_q))
		else $error("step moved during hold");

	// bit counter never passes one byte
	a_bit_range: assert property (@(posedge clk) disable iff (!arst_n)
		bit_q <= BITS_PER_BYTE)
		else $error("bit counter out of range");

	// missing ack is only raised by the polling step
	a_miss_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(miss_q) |-> $past(step_q) == ST_ACK_POLL)
		else $error("ack missing set outside polling");

endmodule

// ----- test/i2c_mbe_line_checker.sv -----
module i2c_mbe_line_checker
	import i2c_mbe_pkg::*;
#(
	parameter int TIMER_WIDTH = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	input  logic                 s_tready,
	input  logic [15:0]          s_tdata,   // wr_data[7:0], send_ack, sda_in
	input  logic [3:0]           s_tuser,   // cmd_valid, action[2:0]
	input  logic                 m_tvalid,
	input  logic                 m_tready,
	input  logic [15:0]          m_tdata,   // scl_out, sda_out, busy_res, done_res,
	                                        // rd_data[7:0], ack_missing
	input  logic                 cfg_valid,
	input  logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	input  logic                 end_of_test,
	output int                   fail_count
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [HALF_W-1:0] HALF_PHASE_RESET = 16'd10;
	localparam logic [TMO_W-1:0]  ACK_LIMIT_RESET  = 8'd250;
	localparam longint            HOLD_MAX         = (64'd1 << TIMER_WIDTH) - 1;
	localparam int                PRINT_LIMIT      = 50;

	// register copies
	logic [HALF_W-1:0] half_phase;
	logic [TMO_W-1:0]  ack_limit;

	// sequencer copy
	step_t                  step;
	logic [TIMER_WIDTH-1:0] hold_cnt;
	logic [3:0]             bit_cnt;
	logic [7:0]             shreg;
	logic [7:0]             poll_cnt;
	logic                   scl_lvl;
	logic                   sda_lvl;
	logic                   miss_flag;
	logic                   ack_sel;
	logic [7:0]             rd_byte;

	// bus levels and status still owed by the block, oldest first
	res_t bus_state_q[$];
	int   res_n;
	int   mismatches = 0;

	assign fail_count = mismatches;

	task automatic report(input string msg);
		if (mismatches < PRINT_LIMIT)
			$display("mismatch at %0t: %s", $realtime, msg);
		mismatches++;
	endtask

	task automatic cmp_field(input string name, input logic [7:0] got, input logic [7:0] want);
		if (got !== want)
			report($sformatf("result %0d %s is %0h, expected %0h", res_n, name, got, want));
	endtask

	function automatic void clear_sequencer();
		half_phase = HALF_PHASE_RESET;
		ack_limit  = ACK_LIMIT_RESET;
		step       = ST_IDLE;
		hold_cnt   = '0;
		bit_cnt    = '0;
		shreg      = '0;
		poll_cnt   = '0;
		scl_lvl    = 1'b1;
		sda_lvl    = 1'b1;
		miss_flag  = 1'b0;
		ack_sel    = 1'b0;
		rd_byte    = '0;
	endfunction

	// hold after a pin change, clipped to what the timer can count
	function automatic void load_hold();
		if (longint'(half_phase) > HOLD_MAX)
			hold_cnt = TIMER_WIDTH'(HOLD_MAX);
		else
			hold_cnt = TIMER_WIDTH'(half_phase);
	endfunction

	// one pin operation of the running sequence, returns 1 on the finishing tick
	function automatic logic run_pin_op(input logic sda_i);
		logic fin;
		fin = 1'b0;
		case (step)
			ST_START_B: begin
				sda_lvl = 1'b0; load_hold(); step = ST_START_C;
			end
			ST_START_C: begin
				scl_lvl = 1'b0; load_hold(); step = ST_FIN;
			end
			ST_STOP_B: begin
				scl_lvl = 1'b1; load_hold(); step = ST_STOP_C;
			end
			ST_STOP_C: begin
				sda_lvl = 1'b1; load_hold(); step = ST_FIN;
			end
			ST_WR_DATA: begin
				sda_lvl = shreg[7];
				shreg   = shreg << 1;
				load_hold();
				step = ST_WR_HIGH;
			end
			ST_WR_HIGH: begin
				scl_lvl = 1'b1; load_hold(); step = ST_WR_LOW;
			end
			ST_WR_LOW: begin
				scl_lvl = 1'b0;
				load_hold();
				bit_cnt = bit_cnt + 4'd1;
				step = (bit_cnt < BITS_PER_BYTE) ? ST_WR_DATA : ST_WR_REL;
			end
			ST_WR_REL: begin
				sda_lvl = 1'b1; load_hold(); step = ST_FIN;
			end
			ST_ACK_HIGH: begin
				scl_lvl  = 1'b1;
				load_hold();
				poll_cnt = '0;
				step = ST_ACK_POLL;
			end
			ST_ACK_POLL: begin
				// low sample is the ack, too many high samples end in a stop
				if (!sda_i) begin
					scl_lvl = 1'b0; load_hold(); step = ST_FIN;
				end else if (poll_cnt >= ack_limit) begin
					miss_flag = 1'b1;
					sda_lvl   = 1'b0;
					load_hold();
					step = ST_STOP_B;
				end else begin
					poll_cnt = poll_cnt + 8'd1;
				end
			end
			ST_RD_SAMPLE: begin
				shreg   = {shreg[6:0], sda_i};
				scl_lvl = 1'b0;
				load_hold();
				bit_cnt = bit_cnt + 4'd1;
				if (bit_cnt < BITS_PER_BYTE) begin
					step = ST_RD_HIGH;
				end else begin
					rd_byte = shreg;
					step = ST_K_DRIVE;
				end
			end
			ST_RD_HIGH: begin
				scl_lvl = 1'b1; load_hold(); step = ST_RD_SAMPLE;
			end
			ST_K_DRIVE: begin
				sda_lvl = !ack_sel; load_hold(); step = ST_K_HIGH;
			end
			ST_K_HIGH: begin
				scl_lvl = 1'b1; load_hold(); step = ST_K_LOW;
			end
			ST_K_LOW: begin
				scl_lvl = 1'b0;
				load_hold();
				step = ack_sel ? ST_K_REL : ST_FIN;
			end
			ST_K_REL: begin
				sda_lvl = 1'b1; load_hold(); step = ST_FIN;
			end
			ST_FIN: begin
				step = ST_IDLE;
				fin  = 1'b1;
			end
			default: step = ST_IDLE;
		endcase
		return fin;
	endfunction

	// command taken while idle, its first pin change happens at once
	function automatic void take_command(input logic [2:0] act, input logic [7:0] data,
			input logic ack);
		case (act)
			ACT_START: begin
				sda_lvl = 1'b1; scl_lvl = 1'b1; load_hold(); step = ST_START_B;
			end
			ACT_STOP: begin
				sda_lvl = 1'b0; load_hold(); step = ST_STOP_B;
			end
			ACT_WRITE: begin
				shreg   = data;
				bit_cnt = '0;
				step    = ST_WR_DATA;
				void'(run_pin_op(1'b0));
			end
			ACT_WAIT: begin
				miss_flag = 1'b0; sda_lvl = 1'b1; load_hold(); step = ST_ACK_HIGH;
			end
			ACT_READ: begin
				ack_sel = ack;
				shreg   = '0;
				bit_cnt = '0;
				sda_lvl = 1'b1;
				scl_lvl = 1'b1;
				load_hold();
				step = ST_RD_SAMPLE;
			end
			default: ;
		endcase
	endfunction

	// advance one tick and give the levels and status after it
	function automatic res_t advance_tick(input tick_t t);
		res_t r;
		logic fin;
		fin = 1'b0;
		if (step == ST_IDLE) begin
			if (t.cmd_valid)
				take_command(t.action, t.wr_data, t.send_ack);
		end else if (hold_cnt != '0) begin
			hold_cnt = hold_cnt - 1'b1;
		end else begin
			fin = run_pin_op(t.sda_in);
		end
		r.scl_out     = scl_lvl;
		r.sda_out     = sda_lvl;
		r.busy_res    = (step != ST_IDLE);
		r.done_res    = fin;
		r.rd_data     = rd_byte;
		r.ack_missing = miss_flag;
		return r;
	endfunction

	// follow register writes, ticks and results
	always @(posedge clk or negedge arst_n) begin
		tick_t t;
		res_t  got;
		res_t  want;
		if (!arst_n) begin
			clear_sequencer();
			bus_state_q.delete();
			res_n = 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_HALF_PHASE:  half_phase = cfg_data[HALF_W-1:0];
					REG_ACK_TIMEOUT: ack_limit  = cfg_data[TMO_W-1:0];
					default: ;
				endcase
			end
			if (s_tvalid && s_tready) begin
				t.wr_data   = s_tdata[7:0];
				t.send_ack  = s_tdata[8];
				t.sda_in    = s_tdata[9];
				t.cmd_valid = s_tuser[0];
				t.action    = s_tuser[3:1];
				bus_state_q.push_back(advance_tick(t));
			end
			if (m_tvalid && m_tready) begin
				got.scl_out     = m_tdata[0];
				got.sda_out     = m_tdata[1];
				got.busy_res    = m_tdata[2];
				got.done_res    = m_tdata[3];
				got.rd_data     = m_tdata[11:4];
				got.ack_missing = m_tdata[12];
				if (bus_state_q.size() == 0) begin
					report($sformatf("result %0d arrived with nothing expected", res_n));
				end else begin
					want = bus_state_q.pop_front();
					cmp_field("scl_out", 8'(got.scl_out), 8'(want.scl_out));
					cmp_field("sda_out", 8'(got.sda_out), 8'(want.sda_out));
					cmp_field("busy_res", 8'(got.busy_res), 8'(want.busy_res));
					cmp_field("done_res", 8'(got.done_res), 8'(want.done_res));
					cmp_field("rd_data", got.rd_data, want.rd_data);
					cmp_field("ack_missing", 8'(got.ack_missing), 8'(want.ack_missing));
				end
				res_n++;
			end
		end
	end

	// anything still owed at the end never came
	always @(posedge end_of_test) begin
		if (bus_state_q.size() != 0)
			report($sformatf("%0d result(s) never arrived", bus_state_q.size()));
	end

endmodule

// ----- test/testbench.sv -----
module testbench;
	timeunit 1ns;
	timeprecision 1ps;
	import i2c_mbe_pkg::*;

	localparam int TIMER_WIDTH = 16;

	// register indexes the block does not implement
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;

	// result bits the stimulus reacts to
	localparam int BUSY_BIT = 2;
	localparam int MISS_BIT = 12;

	// how the sampled sda level is drawn while a command runs
	localparam int SDA_RANDOM   = 0;
	localparam int SDA_HIGH     = 1;
	localparam int SDA_LATE_ACK = 2;
	localparam int SDA_LOW      = 3;

	localparam int CMDS_PER_SETTING = 6;

	logic                 clk         = 1'b0;
	logic                 arst_n      = 1'b0;
	logic                 s_tvalid    = 1'b0;
	logic                 s_tready;
	logic [15:0]          s_tdata     = '0;   // wr_data[7:0], send_ack, sda_in
	logic [3:0]           s_tuser     = '0;   // cmd_valid, action[2:0]
	logic                 m_tvalid;
	logic                 m_tready    = 1'b0;
	logic [15:0]          m_tdata;            // scl_out, sda_out, busy_res, done_res,
	                                          // rd_data[7:0], ack_missing
	logic                 cfg_valid   = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index   = '0;
	logic [CFG_W-1:0]     cfg_data    = '0;
	logic                 end_of_test = 1'b0;
	int                   fail_count;

	// bit 0 idles the source, bit 1 stalls the sink
	logic [1:0] idle_mode      = 2'd0;
	bit         idling_allowed = 1'b1;
	bit         noise_on       = 1'b0;

	int   sent_n   = 0;
	int   got_n    = 0;
	int   idle_idx = -1;
	int   cmds_run = 0;
	logic last_miss = 1'b0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	i2c_master_bit_engine_unit #(.TIMER_WIDTH(TIMER_WIDTH)) DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	i2c_mbe_line_checker #(.TIMER_WIDTH(TIMER_WIDTH)) line_check (
		.clk         (clk),
		.arst_n      (arst_n),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.s_tuser     (s_tuser),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.end_of_test (end_of_test),
		.fail_count  (fail_count)
	);

	// track the latest idle result so the stimulus knows when a command ended
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			got_n     <= got_n + 1;
			last_miss <= m_tdata[MISS_BIT];
			if (!m_tdata[BUSY_BIT])
				idle_idx <= got_n;
		end
	end

	// result sink with random stalls
	initial begin
		int gap;
		@(posedge arst_n);
		forever begin
			gap = idle_mode[1] ? $urandom_range(0, 10) : 0;
			@(negedge clk);
			if (gap != 0) begin
				m_tready <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
		end
	end

	function automatic logic pick_sda(input int mode);
		case (mode)
			SDA_HIGH:     return 1'b1;
			SDA_LOW:      return 1'b0;
			SDA_LATE_ACK: return ($urandom_range(0, 15) != 0);
			default:      return 1'($urandom_range(0, 1));
		endcase
	endfunction

	// one tick transaction on the input channel
	task automatic send_tick(input logic cv, input logic [2:0] act, input logic [7:0] data,
			input logic ack, input logic sda);
		int gap;
		gap = idle_mode[0] ? $urandom_range(0, 10) : 0;
		@(negedge clk);
		if (gap != 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {6'd0, sda, ack, data};
		s_tuser  <= {act, cv};
		do @(posedge clk); while (!s_tready);
		sent_n++;
	endtask

	// offer a command, then keep ticking until the block reports idle after it
	task automatic run_command(input logic [2:0] act, input logic [7:0] data, input logic ack,
			input int mode, input bit poke);
		int   k;
		logic cv;
		idle_mode = idling_allowed ? 2'($urandom_range(0, 3)) : 2'd0;
		k = sent_n;
		send_tick(1'b1, act, data, ack, pick_sda(mode));
		// a second command right behind the first is dropped, unless the first code left the block idle
		if (poke)
			send_tick(1'b1, 3'($urandom_range(0, 7)), 8'($urandom), 1'($urandom_range(0, 1)),
				pick_sda(mode));
		while (idle_idx < k) begin
			cv = noise_on && ($urandom_range(0, 11) == 0);
			send_tick(cv, 3'($urandom_range(0, 7)), 8'($urandom), 1'($urandom_range(0, 1)),
				pick_sda(mode));
		end
		cmds_run++;
	endtask

	function automatic int ack_mode();
		int r;
		r = $urandom_range(0, 19);
		if (r < 14)
			return SDA_LATE_ACK;
		else if (r < 17)
			return SDA_LOW;
		return SDA_HIGH;
	endfunction

	// start, address, ack, one to three data bytes, stop unless an ack was missed
	task automatic bus_transfer();
		logic [7:0] addr;
		int         n;
		addr = 8'($urandom);
		n    = $urandom_range(1, 3);
		run_command(ACT_START, 8'($urandom), 1'($urandom_range(0, 1)), SDA_RANDOM, 1'b0);
		run_command(ACT_WRITE, addr, 1'($urandom_range(0, 1)), SDA_RANDOM, 1'b0);
		run_command(ACT_WAIT, 8'($urandom), 1'($urandom_range(0, 1)), ack_mode(), 1'b0);
		if (last_miss)
			return;
		for (int i = 0; i < n; i++) begin
			if (addr[0]) begin
				run_command(ACT_READ, 8'($urandom), (i != n - 1), SDA_RANDOM, 1'b0);
			end else begin
				run_command(ACT_WRITE, 8'($urandom), 1'($urandom_range(0, 1)), SDA_RANDOM,
					1'b0);
				run_command(ACT_WAIT, 8'($urandom), 1'($urandom_range(0, 1)), ack_mode(),
					1'b0);
				if (last_miss)
					break;
			end
		end
		if (!last_miss)
			run_command(ACT_STOP, 8'($urandom), 1'($urandom_range(0, 1)), SDA_RANDOM, 1'b0);
	endtask

	// mostly well-formed transfers, the rest single commands of any code
	task automatic run_random(input int n_cmds);
		int first;
		first = cmds_run;
		while (cmds_run - first < n_cmds) begin
			if ($urandom_range(0, 4) != 0)
				bus_transfer();
			else
				run_command(3'($urandom_range(0, 7)), 8'($urandom), 1'($urandom_range(0, 1)),
					$urandom_range(0, 3), ($urandom_range(0, 3) == 0));
		end
	endtask

	// tick quietly until the block is idle, then release the input channel
	task automatic settle();
		int k;
		k = sent_n - 1;
		while (idle_idx < k)
			send_tick(1'b0, 3'($urandom_range(0, 7)), 8'($urandom), 1'($urandom_range(0, 1)),
				1'($urandom_range(0, 1)));
		@(negedge clk);
		s_tvalid <= 1'b0;
		// wait until every result has been taken
		while (got_n < sent_n)
			@(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic configure(input logic [CFG_W-1:0] half, input logic [CFG_W-1:0] tmo);
		settle();
		write_reg(REG_HALF_PHASE, half);
		write_reg(REG_ACK_TIMEOUT, tmo);
	endtask

	// run limit
	initial begin
		#50_000_000;
		$display("== FAIL ==");
		$finish;
	end

	initial begin
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// reset timing
		run_command(ACT_START, 8'h00, 1'b0, SDA_HIGH, 1'b0);
		run_command(ACT_STOP, 8'hFF, 1'b1, SDA_LOW, 1'b0);

		// zero hold and zero ack timeout, every command at least once
		configure(16'd0, 16'd0);
		run_command(ACT_START, 8'h00, 1'b0, SDA_RANDOM, 1'b0);
		run_command(ACT_WRITE, 8'hFF, 1'b0, SDA_RANDOM, 1'b0);
		run_command(ACT_WAIT, 8'h00, 1'b1, SDA_LOW, 1'b0);
		run_command(ACT_WRITE, 8'h00, 1'b1, SDA_RANDOM, 1'b1);
		run_command(ACT_WAIT, 8'hFF, 1'b0, SDA_HIGH, 1'b0);
		run_command(ACT_START, 8'hFF, 1'b1, SDA_RANDOM, 1'b0);
		run_command(ACT_WRITE, 8'h5A, 1'b0, SDA_RANDOM, 1'b0);
		run_command(ACT_WAIT, 8'hA5, 1'b0, SDA_LATE_ACK, 1'b0);
		run_command(ACT_START, 8'h00, 1'b0, SDA_RANDOM, 1'b0);
		run_command(ACT_READ, 8'h00, 1'b1, SDA_HIGH, 1'b0);
		run_command(ACT_READ, 8'hFF, 1'b0, SDA_LOW, 1'b0);
		run_command(ACT_STOP, 8'h00, 1'b0, SDA_RANDOM, 1'b1);
		// undefined codes leave the block idle
		run_command(3'd5, 8'hFF, 1'b1, SDA_HIGH, 1'b0);
		run_command(3'd6, 8'h00, 1'b0, SDA_LOW, 1'b0);
		run_command(3'd7, 8'hFF, 1'b1, SDA_RANDOM, 1'b0);

		// random traffic over several settings
		noise_on = 1'b1;
		configure(16'd1, 16'd1);
		write_reg(REG_SPARE_2, 16'($urandom));
		write_reg(REG_SPARE_3, 16'($urandom));
		run_random(CMDS_PER_SETTING);
		configure(16'd2, 16'd3);
		run_random(CMDS_PER_SETTING);
		configure(16'd0, 16'd255);
		run_random(CMDS_PER_SETTING);
		// upper data bits of the timeout write are dropped
		configure(16'd1, 16'hAB05);
		run_random(CMDS_PER_SETTING);
		configure(16'd3, 16'd7);
		run_random(CMDS_PER_SETTING);
		configure(16'd0, 16'd0);
		run_random(CMDS_PER_SETTING);

		// long hold, one short command without idling
		noise_on       = 1'b0;
		idling_allowed = 1'b0;
		configure(16'd40, 16'd255);
		run_command(ACT_STOP, 8'($urandom), 1'($urandom_range(0, 1)), SDA_RANDOM, 1'b0);

		settle();
		@(negedge clk);
		end_of_test <= 1'b1;
		repeat (2) @(negedge clk);
		if (fail_count == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

// ----- i2c_master_bit_engine_unit.f -----
rtl/core/i2c_mbe_pkg.sv
rtl/core/i2c_mbe_seq.sv
rtl/core/i2c_master_bit_engine_unit.sv
test/i2c_mbe_line_checker.sv
test/testbench.sv
